// ===== src/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the temperature sensor poller
// Phase and command codes, item structs, config bundle, saturation helper.
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int NUM_SENSORS_DEF = 2;

   localparam int ADDR_W  = 7;
   localparam int LIMIT_W = 12;
   localparam int TEMP_W  = 8;

   localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RESET = 12'd2000;
   localparam logic [15:0]        NOT_READY_WORD    = 16'h8000;
   localparam logic signed [8:0]  TEMP_HI           = 9'sd127;
   localparam logic signed [8:0]  TEMP_LO           = -9'sd128;

   // per-sensor sequence position
   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_TRIGGERED = 2'd1,
      PH_TRIG_DONE = 2'd2,
      PH_READ_REQ  = 2'd3
   } phase_type;

   // command issued to the bus controller
   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_TRIGGER = 2'd1,
      CMD_READ    = 2'd2
   } cmd_type;

   // register index (paddr[3:2])
   typedef enum logic [1:0] {
      REG_ADDR_A    = 2'd0,
      REG_ADDR_B    = 2'd1,
      REG_ERR_LIMIT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  address_a;
      logic [ADDR_W-1:0]  address_b;
      logic [LIMIT_W-1:0] error_limit;
   } cfg_type;

   typedef struct packed {
      logic       sensor;
      logic       bus_accepted;
      logic       result_ready;
      logic       result_error;
      logic [7:0] read_high;
      logic [7:0] read_low;
   } req_type;

   typedef struct packed {
      cmd_type                  command;
      logic [ADDR_W-1:0]        command_address;
      logic signed [TEMP_W-1:0] temperature;
      logic                     temp_valid;
      logic                     bus_reset;
   } rsp_type;

   // word >>> 7, clamped to signed 8 bits
   function automatic logic signed [TEMP_W-1:0] sat_temp(input logic [15:0] word);
      logic signed [8:0] t;
      t = signed'(word[15:7]);
      if (t > TEMP_HI) begin
         sat_temp = TEMP_HI[TEMP_W-1:0];
      end else if (t < TEMP_LO) begin
         sat_temp = TEMP_LO[TEMP_W-1:0];
      end else begin
         sat_temp = t[TEMP_W-1:0];
      end
   endfunction

endpackage

// ===== src/tsp_csr.sv =====
// ----------------------------------------------------------------------------
// tsp_csr: configuration registers
// APB-style write/read of sensor addresses and the trigger error limit.
// ----------------------------------------------------------------------------
module tsp_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output tsp_pkg::cfg_type  cfg
);

   logic [tsp_pkg::ADDR_W-1:0]  addr_a_ff;
   logic [tsp_pkg::ADDR_W-1:0]  addr_b_ff;
   logic [tsp_pkg::LIMIT_W-1:0] limit_ff;
   logic                        wr_en;
   logic [1:0]                  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_a_ff <= '0;
         addr_b_ff <= '0;
         limit_ff  <= tsp_pkg::ERROR_LIMIT_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            tsp_pkg::REG_ADDR_A:    addr_a_ff <= pwdata[tsp_pkg::ADDR_W-1:0];
            tsp_pkg::REG_ADDR_B:    addr_b_ff <= pwdata[tsp_pkg::ADDR_W-1:0];
            tsp_pkg::REG_ERR_LIMIT: limit_ff  <= pwdata[tsp_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tsp_pkg::REG_ADDR_A:    prdata = 32'(addr_a_ff);
         tsp_pkg::REG_ADDR_B:    prdata = 32'(addr_b_ff);
         tsp_pkg::REG_ERR_LIMIT: prdata = 32'(limit_ff);
         default:                prdata = '0;
      endcase
   end

   assign cfg.address_a   = addr_a_ff;
   assign cfg.address_b   = addr_b_ff;
   assign cfg.error_limit = limit_ff;

endmodule

// ===== src/tsp_engine.sv =====
// ----------------------------------------------------------------------------
// tsp_engine: per-sensor sequencer
// Holds phase and trigger error count per sensor, decodes one poll.
// ----------------------------------------------------------------------------
module tsp_engine #(
   parameter int NUM_SENSORS = tsp_pkg::NUM_SENSORS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              commit,
   input  tsp_pkg::req_type  req,
   input  tsp_pkg::cfg_type  cfg,
   output tsp_pkg::rsp_type  rsp
);

   localparam int SEL_W = $clog2(NUM_SENSORS + 1) + 1;

   tsp_pkg::phase_type          phase_ff [NUM_SENSORS];
   tsp_pkg::phase_type          phase_in [NUM_SENSORS];
   logic [tsp_pkg::LIMIT_W-1:0] count_ff [NUM_SENSORS];
   logic [tsp_pkg::LIMIT_W-1:0] count_in [NUM_SENSORS];

   logic [SEL_W-1:0]            sensor_sel;
   logic                        in_range;
   tsp_pkg::phase_type          cur_phase;
   logic [tsp_pkg::LIMIT_W-1:0] cur_count;
   tsp_pkg::phase_type          nxt_phase;
   logic [tsp_pkg::LIMIT_W-1:0] nxt_count;
   logic [tsp_pkg::LIMIT_W:0]   count_inc;
   logic                        over_limit;
   logic [15:0]                 word;
   logic                        read_retry;

   assign sensor_sel = SEL_W'(req.sensor);
   assign in_range   = sensor_sel < SEL_W'(NUM_SENSORS);
   assign word       = {req.read_high, req.read_low};
   assign count_inc  = {1'b0, cur_count} + 1'b1;
   assign over_limit = count_inc > {1'b0, cfg.error_limit};
   assign read_retry = req.result_error | (word == tsp_pkg::NOT_READY_WORD);

   // select the polled sensor's state
   always_comb begin
      cur_phase = tsp_pkg::PH_IDLE;
      cur_count = '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (sensor_sel == SEL_W'(i)) begin
            cur_phase = phase_ff[i];
            cur_count = count_ff[i];
         end
      end
   end

   // next state
   always_comb begin
      nxt_phase = cur_phase;
      nxt_count = cur_count;
      unique case (cur_phase)
         tsp_pkg::PH_IDLE: begin
            if (req.bus_accepted) nxt_phase = tsp_pkg::PH_TRIGGERED;
         end
         tsp_pkg::PH_TRIGGERED: begin
            if (req.result_ready) begin
               if (req.result_error) begin
                  nxt_phase = tsp_pkg::PH_IDLE;
                  nxt_count = over_limit ? '0 : count_inc[tsp_pkg::LIMIT_W-1:0];
               end else begin
                  nxt_phase = tsp_pkg::PH_TRIG_DONE;
                  nxt_count = '0;
               end
            end
         end
         tsp_pkg::PH_TRIG_DONE: begin
            if (req.bus_accepted) nxt_phase = tsp_pkg::PH_READ_REQ;
         end
         tsp_pkg::PH_READ_REQ: begin
            if (req.result_ready) begin
               nxt_phase = read_retry ? tsp_pkg::PH_TRIG_DONE : tsp_pkg::PH_IDLE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      rsp = '0;
      if (in_range) begin
         unique case (cur_phase)
            tsp_pkg::PH_IDLE: begin
               rsp.command = tsp_pkg::CMD_TRIGGER;
            end
            tsp_pkg::PH_TRIGGERED: begin
               rsp.bus_reset = req.result_ready & req.result_error & over_limit;
            end
            tsp_pkg::PH_TRIG_DONE: begin
               rsp.command = tsp_pkg::CMD_READ;
            end
            tsp_pkg::PH_READ_REQ: begin
               if (req.result_ready && !read_retry) begin
                  rsp.temp_valid  = 1'b1;
                  rsp.temperature = tsp_pkg::sat_temp(word);
               end
            end
         endcase
         if (rsp.command != tsp_pkg::CMD_NONE) begin
            rsp.command_address = req.sensor ? cfg.address_b : cfg.address_a;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
         phase_in[i] = phase_ff[i];
         count_in[i] = count_ff[i];
         if (commit && in_range && sensor_sel == SEL_W'(i)) begin
            phase_in[i] = nxt_phase;
            count_in[i] = nxt_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (reset) begin
            phase_ff[i] <= tsp_pkg::PH_IDLE;
            count_ff[i] <= '0;
         end else begin
            phase_ff[i] <= phase_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

endmodule

// ===== src/temp_sensor_poll_controller.sv =====
// Each poll item is held in the input register, then in the result register;
// the item stays in the input register while rsp_ready holds the result back.
// Throughput: one item per cycle while rsp_ready is high; per-sensor state update
// and decode form one combinational path between input and result registers.
// Reset (synchronous, active high): all sensors idle, error counts zero,
// addresses 0, error limit 2000, both pipeline registers empty.
// ----------------------------------------------------------------------------
// temp_sensor_poll_controller: polls temperature sensors over a bus controller
// Each item is one poll of one sensor with the bus controller's answer; each
// item yields one result with the next command, reading and bus reset flag.
// ----------------------------------------------------------------------------
module temp_sensor_poll_controller #(
   parameter int NUM_SENSORS = tsp_pkg::NUM_SENSORS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // poll items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_sensor,
   input  logic        req_bus_accepted,
   input  logic        req_result_ready,
   input  logic        req_result_error,
   input  logic [7:0]  req_read_high,
   input  logic [7:0]  req_read_low,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_command,
   output logic [6:0]  rsp_command_address,
   output logic signed [7:0] rsp_temperature,
   output logic        rsp_temp_valid,
   output logic        rsp_bus_reset,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   tsp_pkg::cfg_type cfg;
   tsp_pkg::req_type stage_ff;
   tsp_pkg::req_type stage_in;
   logic             stage_valid_ff;
   logic             stage_valid_in;
   tsp_pkg::rsp_type rsp_ff;
   tsp_pkg::rsp_type rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   tsp_pkg::rsp_type eng_rsp;
   logic             req_take;
   logic             commit;

   tsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The stage item moves to the result register when that register is free
   // or being drained; sensor state is updated at the same edge, so a
   // following poll of the same sensor sees the updated state.
   assign commit    = stage_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~stage_valid_ff | commit;
   assign req_take  = req_valid & req_ready;

   tsp_engine #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .commit (commit),
      .req    (stage_ff),
      .cfg    (cfg),
      .rsp    (eng_rsp)
   );

   always_comb begin
      stage_in.sensor       = req_sensor;
      stage_in.bus_accepted = req_bus_accepted;
      stage_in.result_ready = req_result_ready;
      stage_in.result_error = req_result_error;
      stage_in.read_high    = req_read_high;
      stage_in.read_low     = req_read_low;
      stage_valid_in        = req_take | (stage_valid_ff & ~commit);
      rsp_in                = eng_rsp;
      rsp_valid_in          = commit | (rsp_valid_ff & ~rsp_ready);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= stage_in;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_command         = rsp_ff.command;
   assign rsp_command_address = rsp_ff.command_address;
   assign rsp_temperature     = rsp_ff.temperature;
   assign rsp_temp_valid      = rsp_ff.temp_valid;
   assign rsp_bus_reset       = rsp_ff.bus_reset;

   // a reading or a bus reset only comes out of a wait phase: no command
   a_flag_no_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_temp_valid || rsp_bus_reset) |->
         rsp_command == tsp_pkg::CMD_NONE)
      else $error("reading or bus reset together with a command");

   a_temp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_temp_valid |-> rsp_temperature == 8'sd0)
      else $error("temperature not zero without a reading");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == tsp_pkg::CMD_NONE |-> rsp_command_address == 7'd0)
      else $error("address not zero without a command");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !commit |=> stage_valid_ff && $stable(stage_ff))
      else $error("stalled stage item lost or changed");

endmodule

// ===== bench/tb_temp_sensor_poll_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_temp_sensor_poll_controller: self-checking bench for the sensor poller
// Sends poll items from a table of directed cases and then from a generator
// that follows each sensor's sequence. Every result item is compared with the
// typed table result or with the bench model's expectation. The registers are
// set between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_temp_sensor_poll_controller;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int NUM_PHASES   = 6;
   localparam int RAND_POLLS   = 188;     // random items per phase
   localparam int NOISE_PCT    = 15;      // share of items with fully random fields

   // paddr[3:2] = 3 has no register behind it; writes there must be ignored
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   // register setting per phase; -1 means pick one at random
   localparam int PHASE_ADDR_A [NUM_PHASES] = '{127, 42, 0, -1, -1, -1};
   localparam int PHASE_ADDR_B [NUM_PHASES] = '{0, 85, 127, -1, -1, -1};
   localparam int PHASE_LIMIT  [NUM_PHASES] = '{0, 1, 4095, 3, 2000, -1};
   // idle percentages: receiver slow first, then sender slow, then no idling
   localparam int SEND_IDLE    [NUM_PHASES] = '{19, 19, 69, 69, 0, 0};
   localparam int RECV_IDLE    [NUM_PHASES] = '{69, 69, 19, 19, 0, 0};

   // words around the clamp points and the sign change
   localparam logic [15:0] EDGE_WORDS [8] = '{16'h7FFF, 16'h8001, 16'h0000, 16'hFFFF,
                                              16'h3F80, 16'h4000, 16'hC000, 16'hBF80};

   localparam tsp_pkg::rsp_type RSP_QUIET  =
      '{tsp_pkg::CMD_NONE, 7'd0, 8'h00, 1'b0, 1'b0};
   localparam tsp_pkg::rsp_type TRIG_ADDR0 =
      '{tsp_pkg::CMD_TRIGGER, 7'd0, 8'h00, 1'b0, 1'b0};
   localparam tsp_pkg::rsp_type READ_ADDR0 =
      '{tsp_pkg::CMD_READ, 7'd0, 8'h00, 1'b0, 1'b0};
   localparam tsp_pkg::rsp_type TEMP_MAX   =
      '{tsp_pkg::CMD_NONE, 7'd0, 8'h7F, 1'b1, 1'b0};
   localparam tsp_pkg::rsp_type TEMP_MIN   =
      '{tsp_pkg::CMD_NONE, 7'd0, 8'h80, 1'b1, 1'b0};
   localparam tsp_pkg::rsp_type TEMP_ZERO  =
      '{tsp_pkg::CMD_NONE, 7'd0, 8'h00, 1'b1, 1'b0};

   // one directed poll; when known is set the typed result is the expectation
   typedef struct packed {
      tsp_pkg::req_type poll;
      logic             known;
      tsp_pkg::rsp_type result;
   } directed_row_type;

   // Runs with reset settings (both addresses 0, limit 2000).
   // Fields: sensor, bus_accepted, result_ready, result_error, read_high, read_low
   localparam directed_row_type DIRECTED_POLLS [25] = '{
      // sensor 0: trigger refused, then taken
      '{'{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, TRIG_ADDR0},
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, TRIG_ADDR0},
      // write still busy, then it fails: back to idle with one error counted
      '{'{1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF}, 1'b1, RSP_QUIET},
      '{'{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00}, 1'b1, RSP_QUIET},
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, TRIG_ADDR0},
      '{'{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      // read refused, taken, then retried after a bus error and a not-ready word
      '{'{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, READ_ADDR0},
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b0, 1'b0, 1'b1, 1'b0, 8'h80, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      // largest positive word saturates high
      '{'{1'b0, 1'b0, 1'b1, 1'b0, 8'h7F, 8'hFF}, 1'b1, TEMP_MAX},
      // sensor 1: full pass, most negative valid word saturates low
      '{'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b1, 1'b0, 1'b1, 1'b0, 8'h80, 8'h01}, 1'b1, TEMP_MIN},
      // sensor 0 again: small negative word reads as minus one
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, 8'h80}, 1'b0, RSP_QUIET},
      // sensor 1: zero reading
      '{'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, RSP_QUIET},
      '{'{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00}, 1'b1, TEMP_ZERO}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_sensor;
   logic        req_bus_accepted;
   logic        req_result_ready;
   logic        req_result_error;
   logic [7:0]  req_read_high;
   logic [7:0]  req_read_low;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_command;
   logic [6:0]  rsp_command_address;
   logic signed [7:0] rsp_temperature;
   logic        rsp_temp_valid;
   logic        rsp_bus_reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // bench copy of the block's state and registers
   tsp_pkg::phase_type          sensor_phase   [tsp_pkg::NUM_SENSORS_DEF];
   logic [tsp_pkg::LIMIT_W-1:0] trig_err_count [tsp_pkg::NUM_SENSORS_DEF];
   logic [tsp_pkg::ADDR_W-1:0]  cfg_addr_a;
   logic [tsp_pkg::ADDR_W-1:0]  cfg_addr_b;
   logic [tsp_pkg::LIMIT_W-1:0] cfg_err_limit;

   tsp_pkg::rsp_type pending_results [$];      // expected result items, oldest first
   int      fail_count    = 0;
   int      cycle_count   = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   temp_sensor_poll_controller dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sensor          (req_sensor),
      .req_bus_accepted    (req_bus_accepted),
      .req_result_ready    (req_result_ready),
      .req_result_error    (req_result_error),
      .req_read_high       (req_read_high),
      .req_read_low        (req_read_low),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_command         (rsp_command),
      .rsp_command_address (rsp_command_address),
      .rsp_temperature     (rsp_temperature),
      .rsp_temp_valid      (rsp_temp_valid),
      .rsp_bus_reset       (rsp_bus_reset),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Next command and reading for one poll; advances the bench state.
   function automatic tsp_pkg::rsp_type predict_poll(input tsp_pkg::req_type p);
      tsp_pkg::rsp_type          r;
      logic [tsp_pkg::LIMIT_W:0] bumped;
      logic signed [15:0]        word_s;
      int                        deg;
      r = RSP_QUIET;
      unique case (sensor_phase[p.sensor])
         tsp_pkg::PH_IDLE: begin
            r.command = tsp_pkg::CMD_TRIGGER;
            if (p.bus_accepted) sensor_phase[p.sensor] = tsp_pkg::PH_TRIGGERED;
         end
         tsp_pkg::PH_TRIGGERED: begin
            if (p.result_ready && p.result_error) begin
               // count is checked after the bump, so it wraps to 0 instead of overflowing
               bumped = {1'b0, trig_err_count[p.sensor]} + 1'b1;
               sensor_phase[p.sensor] = tsp_pkg::PH_IDLE;
               if (bumped > {1'b0, cfg_err_limit}) begin
                  r.bus_reset = 1'b1;
                  bumped      = '0;
               end
               trig_err_count[p.sensor] = bumped[tsp_pkg::LIMIT_W-1:0];
            end else if (p.result_ready) begin
               sensor_phase[p.sensor]   = tsp_pkg::PH_TRIG_DONE;
               trig_err_count[p.sensor] = '0;
            end
         end
         tsp_pkg::PH_TRIG_DONE: begin
            r.command = tsp_pkg::CMD_READ;
            if (p.bus_accepted) sensor_phase[p.sensor] = tsp_pkg::PH_READ_REQ;
         end
         default: begin
            word_s = {p.read_high, p.read_low};
            if (p.result_ready &&
                (p.result_error || word_s == tsp_pkg::NOT_READY_WORD)) begin
               sensor_phase[p.sensor] = tsp_pkg::PH_TRIG_DONE;     // read is retried
            end else if (p.result_ready) begin
               deg = word_s;
               deg = deg >>> 7;                          // floor division by 128
               if (deg > 127) deg = 127;
               if (deg < -128) deg = -128;
               r.temperature = deg[7:0];
               r.temp_valid  = 1'b1;
               sensor_phase[p.sensor] = tsp_pkg::PH_IDLE;
            end
         end
      endcase
      if (r.command != tsp_pkg::CMD_NONE) begin
         r.command_address = p.sensor ? cfg_addr_b : cfg_addr_a;
      end
      return r;
   endfunction

   // Random poll, mostly the answer a working bus would give in the sensor's
   // current phase so the sequence gets to the read; the rest is noise.
   function automatic tsp_pkg::req_type make_poll();
      tsp_pkg::req_type p;
      int               pick;
      p = 20'($urandom);
      if ($urandom_range(99) < NOISE_PCT) return p;
      unique case (sensor_phase[p.sensor])
         tsp_pkg::PH_IDLE, tsp_pkg::PH_TRIG_DONE: begin
            p.bus_accepted = ($urandom_range(5) != 0);
         end
         tsp_pkg::PH_TRIGGERED: begin
            p.result_ready = ($urandom_range(5) != 0);
            p.result_error = ($urandom_range(99) < 35);   // feed the error counter
         end
         default: begin
            p.result_ready = ($urandom_range(5) != 0);
            p.result_error = ($urandom_range(9) == 0);
            pick = $urandom_range(9);
            if (pick == 0) begin
               {p.read_high, p.read_low} = tsp_pkg::NOT_READY_WORD;
            end else if (pick < 4) begin
               {p.read_high, p.read_low} = EDGE_WORDS[$urandom_range(7)];
            end
         end
      endcase
      return p;
   endfunction

   // One poll item: random idle cycles, then hold valid until the handshake.
   // Entered and left at a falling edge.
   task automatic send_poll(input tsp_pkg::req_type poll, input logic known,
                            input tsp_pkg::rsp_type typed);
      tsp_pkg::rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sensor       <= poll.sensor;
      req_bus_accepted <= poll.bus_accepted;
      req_result_ready <= poll.result_ready;
      req_result_error <= poll.result_error;
      req_read_high    <= poll.read_high;
      req_read_low     <= poll.read_low;
      do @(posedge clock); while (!req_ready);
      predicted = predict_poll(poll);
      pending_results.push_back(known ? typed : predicted);
      @(negedge clock);
   endtask

   // Stop sending and wait for every outstanding result, plus pipeline slack.
   task automatic settle_polls();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write followed by a read back of the same register.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] want;
      logic        mapped;
      mapped = 1'b1;
      want   = '0;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      unique case (idx)
         tsp_pkg::REG_ADDR_A: begin
            cfg_addr_a = value[tsp_pkg::ADDR_W-1:0];
            want       = 32'(value[tsp_pkg::ADDR_W-1:0]);
         end
         tsp_pkg::REG_ADDR_B: begin
            cfg_addr_b = value[tsp_pkg::ADDR_W-1:0];
            want       = 32'(value[tsp_pkg::ADDR_W-1:0]);
         end
         tsp_pkg::REG_ERR_LIMIT: begin
            cfg_err_limit = value[tsp_pkg::LIMIT_W-1:0];
            want          = 32'(value[tsp_pkg::LIMIT_W-1:0]);
         end
         default: mapped = 1'b0;
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (mapped && prdata !== want) begin
         $error("prdata at register %0d: expected %0h, got %0h", idx, want, prdata);
         fail_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      // leave the bus idle before the next access
      @(negedge clock);
   endtask

   // Receiver: ready is redrawn every cycle at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Result checker: every accepted result item against the oldest expectation.
   always @(posedge clock) begin : result_check
      tsp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with none expected: command %0d temperature %0d",
                   rsp_command, rsp_temperature);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_command !== want.command) begin
               $error("command: expected %0d, got %0d", want.command, rsp_command);
               fail_count++;
            end
            if (rsp_command_address !== want.command_address) begin
               $error("command_address: expected %0d, got %0d",
                      want.command_address, rsp_command_address);
               fail_count++;
            end
            if (rsp_temperature !== want.temperature) begin
               $error("temperature: expected %0d, got %0d", want.temperature, rsp_temperature);
               fail_count++;
            end
            if (rsp_temp_valid !== want.temp_valid) begin
               $error("temp_valid: expected %0d, got %0d", want.temp_valid, rsp_temp_valid);
               fail_count++;
            end
            if (rsp_bus_reset !== want.bus_reset) begin
               $error("bus_reset: expected %0d, got %0d", want.bus_reset, rsp_bus_reset);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("temp_sensor_poll_controller verification failed");
         $finish;
      end
   end

   initial begin
      int ph;
      int n;
      int drain;
      logic [31:0] addr_a;
      logic [31:0] addr_b;
      logic [31:0] limit;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sensor       = 1'b0;
      req_bus_accepted = 1'b0;
      req_result_ready = 1'b0;
      req_result_error = 1'b0;
      req_read_high    = '0;
      req_read_low     = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;

      // reset values of the bench model
      cfg_addr_a    = '0;
      cfg_addr_b    = '0;
      cfg_err_limit = tsp_pkg::ERROR_LIMIT_RESET;
      for (n = 0; n < tsp_pkg::NUM_SENSORS_DEF; n++) begin
         sensor_phase[n]   = tsp_pkg::PH_IDLE;
         trig_err_count[n] = '0;
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed cases with reset register values
      send_idle_pct = SEND_IDLE[0];
      recv_idle_pct = RECV_IDLE[0];
      foreach (DIRECTED_POLLS[i]) begin
         send_poll(DIRECTED_POLLS[i].poll, DIRECTED_POLLS[i].known, DIRECTED_POLLS[i].result);
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         // registers change only with the pipeline empty
         settle_polls();
         addr_a = (PHASE_ADDR_A[ph] < 0) ? 32'($urandom_range(127)) : 32'(PHASE_ADDR_A[ph]);
         addr_b = (PHASE_ADDR_B[ph] < 0) ? 32'($urandom_range(127)) : 32'(PHASE_ADDR_B[ph]);
         limit  = (PHASE_LIMIT[ph] < 0) ? 32'($urandom_range(6, 1)) : 32'(PHASE_LIMIT[ph]);
         // junk in the upper bits must be dropped by the register
         write_csr(tsp_pkg::REG_ADDR_A, (32'($urandom) & ~32'h7F) | addr_a);
         write_csr(tsp_pkg::REG_ADDR_B, (32'($urandom) & ~32'h7F) | addr_b);
         write_csr(tsp_pkg::REG_ERR_LIMIT, (32'($urandom) & ~32'hFFF) | limit);
         if (ph == 1) write_csr(REG_UNMAPPED, 32'hFFFF_FFFF);
         send_idle_pct = SEND_IDLE[ph];
         recv_idle_pct = RECV_IDLE[ph];

         for (n = 0; n < RAND_POLLS; n++) begin
            // now and then let everything drain before the next item
            if ($urandom_range(149) == 0) settle_polls();
            send_poll(make_poll(), 1'b0, RSP_QUIET);
         end
      end

      req_valid <= 1'b0;
      drain = 0;
      while (pending_results.size() != 0 && drain < 5000) begin
         @(negedge clock);
         drain++;
      end
      repeat (8) @(negedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected result items never arrived", pending_results.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("temp_sensor_poll_controller verification clean");
      end else begin
         $display("temp_sensor_poll_controller verification failed");
      end
      $finish;
   end

endmodule

// ===== temp_sensor_poll_controller.f =====
src/tsp_pkg.sv
src/tsp_csr.sv
src/tsp_engine.sv
src/temp_sensor_poll_controller.sv
bench/tb_temp_sensor_poll_controller.sv
